// File: rtl/minv_pkg.sv
// package: constants, types and state encoding for the inversion-minimum core
package minv_pkg;

  localparam int MAX_N  = 1024;
  localparam int IDX_W  = $clog2(MAX_N);
  localparam int CNT_W  = IDX_W + 1;
  localparam int SPAN_W = IDX_W + 2;
  localparam int VAL_W  = 11;
  localparam int RES_W  = 19;
  localparam int INV_W  = 20;
  localparam int ACC_W  = 23;

  localparam logic [RES_W-1:0] OUT_MAX = {RES_W{1'b1}};

  typedef logic [VAL_W-1:0]        value_t;
  typedef logic [IDX_W-1:0]        index_t;
  typedef logic [CNT_W-1:0]        count_t;
  typedef logic [SPAN_W-1:0]       span_t;
  typedef logic [INV_W-1:0]        inv_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [RES_W-1:0]        result_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SEG,
    ST_MERGE_RD,
    ST_MERGE_WR,
    ST_WALK_RD,
    ST_WALK_ADD,
    ST_DONE
  } state_t;

endpackage

// File: rtl/minv_item_if.sv
// stream interfaces for permutation elements and results
interface minv_item_if;
  logic                  valid;
  logic                  ready;
  minv_pkg::value_t      perm_value;
  logic                  is_final;
  modport source (output valid, perm_value, is_final, input ready);
  modport sink   (input valid, perm_value, is_final, output ready);
endinterface

interface minv_result_if;
  logic                  valid;
  logic                  ready;
  minv_pkg::result_t     min_inversions;
  modport source (output valid, min_inversions, input ready);
  modport sink   (input valid, min_inversions, output ready);
endinterface

// File: rtl/min_inversions_over_value_shifts_core.sv
// top level: least inversion count over all cyclic value shifts of a permutation
//
// items carries one permutation element per request, is_final marks the last.
// elements load at one per cycle, while the block sits in its load state,
// into a value memory, and each in-range value's position goes into a
// position memory. after the final request the block counts inversions
// with a bottom-up merge sort that ping-pongs between two value memories
// over ceil(log2 n) passes, each merge step reading a pair and writing one
// element. it then walks the n value shifts through the position memory.
// result carries min_inversions, held until taken. the next permutation may
// load while a result waits; a finished count waits in its last state until
// the earlier result is taken. reset clears the control state only: the
// memories keep whatever they held and need no clearing pass.
module min_inversions_over_value_shifts_core (
  input  logic          clk,
  input  logic          rst,
  minv_item_if.sink     items,
  minv_result_if.source result
);

  minv_pkg::state_t state, state_next;

  minv_pkg::value_t mem0 [minv_pkg::MAX_N];
  minv_pkg::value_t mem1 [minv_pkg::MAX_N];
  minv_pkg::index_t pos_mem [minv_pkg::MAX_N];

  minv_pkg::value_t rd_a0, rd_b0, rd_a1, rd_b1;
  minv_pkg::index_t pos_rd;

  minv_pkg::count_t count, n, a, b, k, i;
  minv_pkg::span_t  lo, mid, hi, w;
  logic             src;
  minv_pkg::inv_t   inv;
  minv_pkg::acc_t   running, best;

  logic             accept, store_elem, pos_valid, take_a, a_live;
  minv_pkg::value_t da, db, wr_data;
  minv_pkg::count_t count_inc;
  minv_pkg::span_t  lo_w, lo_2w, n_span;
  minv_pkg::acc_t   walk_sum;
  minv_pkg::result_t sat;

  assign accept     = items.valid && items.ready;
  assign store_elem = count < minv_pkg::count_t'(minv_pkg::MAX_N);
  assign pos_valid  = items.perm_value != '0 &&
                      items.perm_value <= minv_pkg::value_t'(minv_pkg::MAX_N);
  assign count_inc  = store_elem ? count + 1'b1 : count;
  assign da         = src ? rd_a1 : rd_a0;
  assign db         = src ? rd_b1 : rd_b0;
  assign a_live     = minv_pkg::span_t'(a) < mid;
  assign take_a     = a_live && (minv_pkg::span_t'(b) >= hi || da <= db);
  assign wr_data    = take_a ? da : db;
  assign n_span     = minv_pkg::span_t'(n);
  assign lo_w       = lo + w;
  assign lo_2w      = lo + (w << 1);
  assign walk_sum   = running + minv_pkg::acc_t'(n)
                      - (minv_pkg::acc_t'(pos_rd) <<< 1) - minv_pkg::acc_t'(1);
  assign sat        = best < 0 ? '0
                      : (best > minv_pkg::acc_t'(minv_pkg::OUT_MAX) ? minv_pkg::OUT_MAX
                         : minv_pkg::result_t'(best));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      minv_pkg::ST_LOAD: begin
        if (accept && items.is_final) begin
          state_next = (count_inc <= minv_pkg::count_t'(1)) ? minv_pkg::ST_WALK_RD
                                                            : minv_pkg::ST_SEG;
        end
      end
      minv_pkg::ST_SEG: begin
        if (lo >= n_span) begin
          if ((w << 1) >= n_span) state_next = minv_pkg::ST_WALK_RD;
        end else begin
          state_next = minv_pkg::ST_MERGE_RD;
        end
      end
      minv_pkg::ST_MERGE_RD: state_next = minv_pkg::ST_MERGE_WR;
      minv_pkg::ST_MERGE_WR: begin
        state_next = (minv_pkg::span_t'(k) + 1'b1 == hi) ? minv_pkg::ST_SEG
                                                         : minv_pkg::ST_MERGE_RD;
      end
      minv_pkg::ST_WALK_RD:  state_next = minv_pkg::ST_WALK_ADD;
      minv_pkg::ST_WALK_ADD: begin
        state_next = (i + 1'b1 == n) ? minv_pkg::ST_DONE : minv_pkg::ST_WALK_RD;
      end
      minv_pkg::ST_DONE: begin
        if (!result.valid || result.ready) state_next = minv_pkg::ST_LOAD;
      end
      default: state_next = minv_pkg::ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    items.ready = (state == minv_pkg::ST_LOAD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= minv_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // value memories
  always_ff @(posedge clk) begin
    if (state == minv_pkg::ST_LOAD && accept && store_elem) begin
      mem0[count[minv_pkg::IDX_W-1:0]] <= items.perm_value;
    end else if (state == minv_pkg::ST_MERGE_WR && src) begin
      mem0[k[minv_pkg::IDX_W-1:0]] <= wr_data;
    end
    if (state == minv_pkg::ST_MERGE_WR && !src) begin
      mem1[k[minv_pkg::IDX_W-1:0]] <= wr_data;
    end
    rd_a0 <= mem0[a[minv_pkg::IDX_W-1:0]];
    rd_b0 <= mem0[b[minv_pkg::IDX_W-1:0]];
    rd_a1 <= mem1[a[minv_pkg::IDX_W-1:0]];
    rd_b1 <= mem1[b[minv_pkg::IDX_W-1:0]];
  end

  // position memory
  always_ff @(posedge clk) begin
    if (accept && store_elem && pos_valid) begin
      pos_mem[minv_pkg::IDX_W'(items.perm_value - 1'b1)] <= count[minv_pkg::IDX_W-1:0];
    end
    pos_rd <= pos_mem[i[minv_pkg::IDX_W-1:0]];
  end

  // load counters, merge and walk datapath, and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      result.valid <= 1'b0;
    end else begin
      if (state == minv_pkg::ST_DONE && (!result.valid || result.ready)) begin
        result.valid          <= 1'b1;
        result.min_inversions <= sat;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        minv_pkg::ST_LOAD: begin
          if (accept) begin
            count <= items.is_final ? '0 : count_inc;
            if (items.is_final) begin
              n       <= count_inc;
              w       <= minv_pkg::span_t'(1);
              lo      <= '0;
              src     <= 1'b0;
              inv     <= '0;
              i       <= '0;
              running <= '0;
              best    <= '0;
            end
          end
        end
        minv_pkg::ST_SEG: begin
          if (lo >= n_span) begin
            if ((w << 1) >= n_span) begin
              running <= minv_pkg::acc_t'(inv);
              best    <= minv_pkg::acc_t'(inv);
              i       <= '0;
            end else begin
              w   <= w << 1;
              lo  <= '0;
              src <= ~src;
            end
          end else begin
            mid <= (lo_w < n_span) ? lo_w : n_span;
            hi  <= (lo_2w < n_span) ? lo_2w : n_span;
            a   <= minv_pkg::count_t'(lo);
            b   <= minv_pkg::count_t'((lo_w < n_span) ? lo_w : n_span);
            k   <= minv_pkg::count_t'(lo);
          end
        end
        minv_pkg::ST_MERGE_RD: begin
        end
        minv_pkg::ST_MERGE_WR: begin
          if (take_a) begin
            a <= a + 1'b1;
          end else begin
            b <= b + 1'b1;
            if (a_live) inv <= inv + minv_pkg::inv_t'(mid - minv_pkg::span_t'(a));
          end
          k <= k + 1'b1;
          if (minv_pkg::span_t'(k) + 1'b1 == hi) lo <= hi;
        end
        minv_pkg::ST_WALK_RD: begin
        end
        minv_pkg::ST_WALK_ADD: begin
          running <= walk_sum;
          if (walk_sum < best) best <= walk_sum;
          i <= i + 1'b1;
        end
        minv_pkg::ST_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

endmodule
